FILE: src/stk_pkg.sv
// Shared types, constants, keyword tables and character helpers for the token highlighter.
`default_nettype none

package stk_pkg;

   localparam int MAX_WORD_LEN = 63;
   localparam int WLEN_BITS    = 6;
   localparam int KW_CHARS     = 11;
   localparam int KW_BITS      = 8 * KW_CHARS;
   localparam int POS_BITS     = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef enum logic [1:0] {
      LANG_BASIC = 2'd0,
      LANG_PILOT = 2'd1,
      LANG_LOGO  = 2'd2,
      LANG_NONE  = 2'd3
   } language_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_STRING,
      MODE_COMMENT,
      MODE_NUMBER
   } lex_mode_type;

   typedef enum logic [1:0] {
      CLS_KEYWORD = 2'd0,
      CLS_STRING  = 2'd1,
      CLS_COMMENT = 2'd2,
      CLS_NUMBER  = 2'd3
   } span_class_type;

   typedef struct packed {
      logic                last_span;
      span_class_type      span_class;
      logic [15:0]         span_end;
      logic [15:0]         span_start;
   } span_type;

   typedef struct packed {
      logic [1:0] count;
      span_type   first;
      span_type   second;
   } span_push_type;

   localparam int KW_BASIC_N = 50;
   localparam int KW_PILOT_N = 1;
   localparam int KW_LOGO_N  = 31;

   localparam logic [KW_BITS-1:0] KW_BASIC [KW_BASIC_N] = '{
      KW_BITS'("PRINT"), KW_BITS'("LET"), KW_BITS'("IF"), KW_BITS'("THEN"),
      KW_BITS'("ELSE"), KW_BITS'("FOR"), KW_BITS'("TO"), KW_BITS'("STEP"),
      KW_BITS'("NEXT"), KW_BITS'("WHILE"), KW_BITS'("WEND"), KW_BITS'("DO"),
      KW_BITS'("LOOP"), KW_BITS'("UNTIL"), KW_BITS'("GOTO"), KW_BITS'("GOSUB"),
      KW_BITS'("RETURN"), KW_BITS'("INPUT"), KW_BITS'("READ"), KW_BITS'("DATA"),
      KW_BITS'("DIM"), KW_BITS'("REM"), KW_BITS'("END"), KW_BITS'("CLS"),
      KW_BITS'("LOCATE"), KW_BITS'("COLOR"), KW_BITS'("LINE"), KW_BITS'("CIRCLE"),
      KW_BITS'("PSET"), KW_BITS'("PRESET"), KW_BITS'("ABS"), KW_BITS'("SIN"),
      KW_BITS'("COS"), KW_BITS'("TAN"), KW_BITS'("ATN"), KW_BITS'("SQR"),
      KW_BITS'("INT"), KW_BITS'("RND"), KW_BITS'("LEN"), KW_BITS'("MID"),
      KW_BITS'("LEFT"), KW_BITS'("RIGHT"), KW_BITS'("CHR"), KW_BITS'("ASC"),
      KW_BITS'("STR"), KW_BITS'("VAL"), KW_BITS'("AND"), KW_BITS'("OR"),
      KW_BITS'("NOT"), KW_BITS'("XOR")
   };

   localparam logic [KW_BITS-1:0] KW_PILOT [KW_PILOT_N] = '{KW_BITS'("END")};

   localparam logic [KW_BITS-1:0] KW_LOGO [KW_LOGO_N] = '{
      KW_BITS'("FORWARD"), KW_BITS'("FD"), KW_BITS'("BACK"), KW_BITS'("BK"),
      KW_BITS'("LEFT"), KW_BITS'("LT"), KW_BITS'("RIGHT"), KW_BITS'("RT"),
      KW_BITS'("PENUP"), KW_BITS'("PU"), KW_BITS'("PENDOWN"), KW_BITS'("PD"),
      KW_BITS'("SETPENCOLOR"), KW_BITS'("SETPC"), KW_BITS'("SETPENSIZE"),
      KW_BITS'("HOME"), KW_BITS'("CLEARSCREEN"), KW_BITS'("CS"),
      KW_BITS'("HIDETURTLE"), KW_BITS'("HT"), KW_BITS'("SHOWTURTLE"), KW_BITS'("ST"),
      KW_BITS'("REPEAT"), KW_BITS'("TO"), KW_BITS'("END"), KW_BITS'("IF"),
      KW_BITS'("IFELSE"), KW_BITS'("MAKE"), KW_BITS'("PRINT"), KW_BITS'("OUTPUT"),
      KW_BITS'("STOP")
   };

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

   // Character i of the word sits at chars[8*i +: 8]; the folded word is
   // right-aligned so it compares directly with a zero-extended literal.
   function automatic logic keyword_hit(input logic [KW_BITS-1:0]   chars,
                                        input logic [WLEN_BITS-1:0] len,
                                        input language_type         lang);
      logic [KW_BITS-1:0] w;
      logic               hit;
      w   = '0;
      hit = 1'b0;
      for (int i = 0; i < KW_CHARS; i++) begin
         if (WLEN_BITS'(i) < len) begin
            w = {w[KW_BITS-9:0], fold_upper(chars[8*i +: 8])};
         end
      end
      if (len != '0 && len <= WLEN_BITS'(KW_CHARS)) begin
         case (lang)
            LANG_BASIC: begin
               for (int k = 0; k < KW_BASIC_N; k++) begin
                  if (w == KW_BASIC[k]) hit = 1'b1;
               end
            end
            LANG_PILOT: begin
               for (int k = 0; k < KW_PILOT_N; k++) begin
                  if (w == KW_PILOT[k]) hit = 1'b1;
               end
            end
            LANG_LOGO: begin
               for (int k = 0; k < KW_LOGO_N; k++) begin
                  if (w == KW_LOGO[k]) hit = 1'b1;
               end
            end
            default: hit = 1'b0;
         endcase
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

FILE: src/stk_span_fifo.sv
// Result queue: takes up to two spans per cycle, delivers one span per transaction.
`default_nettype none

module stk_span_fifo
   import stk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire span_push_type      push,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      span_type           out_span,
   output      logic [FIFO_CW-1:0] level
);

   span_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;
   logic [FIFO_AW-1:0]   wr_ptr_plus1;

   assign pop          = out_valid && out_ready;
   assign wr_ptr_plus1 = wr_ptr_ff + FIFO_AW'(1);
   assign wr_ptr_in    = wr_ptr_ff + FIFO_AW'(push.count);
   assign rd_ptr_in    = rd_ptr_ff + FIFO_AW'(pop);
   assign count_in     = count_ff + FIFO_CW'(push.count) - FIFO_CW'(pop);

   assign out_valid = count_ff != '0;
   assign out_span  = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_plus1] <= push.second;
      end
   end

endmodule

`default_nettype wire

FILE: src/source_token_highlighter.sv
// Top level of the source token highlighter: lexer stage and result queue.
//
// Takes one text character per transaction on req_ and reports keyword, string,
// comment and number spans on rsp_. One character is accepted every cycle that
// req_tready is high; a character produces zero, one or two spans, and the rsp_
// side delivers one span per cycle that rsp_tready is high, so a character that
// closes one token and ends the text puts two spans on the output. A character's
// first span reaches rsp_ once the input register has taken the character and
// the span is written into the eight-entry result queue that decouples the
// sides. req_tready drops while more than four spans wait in it. csr_ is always
// ready; the user must write the language register over it only while no text
// is in flight; the block does not enforce it. No clearing pass follows reset.
`default_nettype none

module source_token_highlighter
   import stk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // [15:0] span_start, [31:16] span_end,
                                         // [33:32] span_class, [39:34] zero
   output      logic        rsp_tlast,   // last_span
   input  wire logic        csr_tvalid,
   output      logic        csr_tready,
   input  wire logic [7:0]  csr_tdata    // [1:0] language, [7:2] ignored
);

   language_type           lang_ff;
   logic                   s_valid_ff;
   logic [7:0]             s_byte_ff;
   logic                   s_eot_ff;

   lex_mode_type           mode_ff, mode_in, mode_mid;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [POS_BITS-1:0]    ts_ff, ts_in;
   logic [WLEN_BITS-1:0]   wlen_ff, wlen_in;
   logic [KW_BITS-1:0]     chars_ff, chars_in;

   logic                   req_accept;
   logic [POS_BITS-1:0]    pos_next;
   logic                   c_alpha, c_digit, c_quote, c_nl, c_dot, c_cmt;
   logic                   word_cont, used, start_tok;
   logic                   kw_old, kw_new;
   logic                   close_v, tail_v;
   span_type               close_span, tail_span;
   span_push_type          push;
   span_type               out_span;
   logic [FIFO_CW-1:0]     level;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = level <= FIFO_CW'(FIFO_DEPTH - 4);
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lang_ff    <= LANG_BASIC;
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= req_accept;
         if (csr_tvalid && csr_tready) begin
            lang_ff <= language_type'(csr_tdata[1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s_byte_ff <= req_tdata;
         s_eot_ff  <= req_tlast;
      end
   end

   assign pos_next = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_BITS'(1);
   assign c_alpha  = is_alpha(s_byte_ff);
   assign c_digit  = is_digit(s_byte_ff);
   assign c_quote  = s_byte_ff == CH_QUOTE;
   assign c_nl     = s_byte_ff == CH_NL;
   assign c_dot    = s_byte_ff == CH_DOT;
   assign c_cmt    = (s_byte_ff == CH_APOS && lang_ff == LANG_BASIC)
                  || (s_byte_ff == CH_SEMI && lang_ff == LANG_LOGO);

   assign word_cont = mode_ff == MODE_WORD && (c_alpha || c_digit)
                   && wlen_ff < WLEN_BITS'(MAX_WORD_LEN);
   assign used      = word_cont || mode_ff == MODE_STRING
                   || (mode_ff == MODE_COMMENT && !c_nl)
                   || (mode_ff == MODE_NUMBER && (c_digit || c_dot));
   assign start_tok = !used && (c_alpha || c_quote || c_cmt || c_digit);

   always_comb begin
      chars_in = chars_ff;
      for (int i = 0; i < KW_CHARS; i++) begin
         if (word_cont && wlen_ff == WLEN_BITS'(i)) begin
            chars_in[8*i +: 8] = s_byte_ff;
         end
      end
      if (!used && c_alpha) begin
         chars_in[7:0] = s_byte_ff;
      end
   end

   assign wlen_in = word_cont          ? wlen_ff + WLEN_BITS'(1)
                  : (!used && c_alpha) ? WLEN_BITS'(1)
                  : wlen_ff;
   assign ts_in   = start_tok ? pos_ff : ts_ff;
   assign pos_in  = s_eot_ff ? '0 : pos_next;

   assign kw_old = keyword_hit(chars_ff, wlen_ff, lang_ff);
   assign kw_new = keyword_hit(chars_in, wlen_in, lang_ff);

   // next state
   always_comb begin
      mode_mid = mode_ff;
      unique case (mode_ff)
         MODE_WORD:    if (!word_cont) mode_mid = MODE_IDLE;
         MODE_STRING:  if (c_quote) mode_mid = MODE_IDLE;
         MODE_COMMENT: if (c_nl) mode_mid = MODE_IDLE;
         MODE_NUMBER:  if (!(c_digit || c_dot)) mode_mid = MODE_IDLE;
         default:      mode_mid = MODE_IDLE;
      endcase
      if (!used) begin
         if (c_alpha)       mode_mid = MODE_WORD;
         else if (c_quote)  mode_mid = MODE_STRING;
         else if (c_cmt)    mode_mid = MODE_COMMENT;
         else if (c_digit)  mode_mid = MODE_NUMBER;
      end
      mode_in = s_eot_ff ? MODE_IDLE : mode_mid;
   end

   // outputs
   always_comb begin
      close_v                = 1'b0;
      close_span.span_start  = ts_ff;
      close_span.span_end    = pos_ff;
      close_span.span_class  = CLS_KEYWORD;
      close_span.last_span   = 1'b1;
      unique case (mode_ff)
         MODE_WORD: begin
            close_v = !word_cont && kw_old;
         end
         MODE_STRING: begin
            close_v               = c_quote;
            close_span.span_end   = pos_next;
            close_span.span_class = CLS_STRING;
         end
         MODE_COMMENT: begin
            close_v               = c_nl;
            close_span.span_class = CLS_COMMENT;
         end
         MODE_NUMBER: begin
            close_v               = !(c_digit || c_dot);
            close_span.span_class = CLS_NUMBER;
         end
         default: close_v = 1'b0;
      endcase

      tail_span.span_start = ts_in;
      tail_span.span_end   = pos_next;
      tail_span.last_span  = 1'b1;
      tail_span.span_class = CLS_KEYWORD;
      tail_v               = 1'b0;
      unique case (mode_mid)
         MODE_WORD: begin
            tail_v = kw_new;
         end
         MODE_STRING: begin
            tail_v               = 1'b1;
            tail_span.span_class = CLS_STRING;
         end
         MODE_COMMENT: begin
            tail_v               = 1'b1;
            tail_span.span_class = CLS_COMMENT;
         end
         MODE_NUMBER: begin
            tail_v               = 1'b1;
            tail_span.span_class = CLS_NUMBER;
         end
         default: tail_v = 1'b0;
      endcase
      tail_v = tail_v && s_eot_ff;

      push.first  = close_v ? close_span : tail_span;
      push.second = tail_span;
      if (close_v && tail_v) begin
         push.first.last_span = 1'b0;
      end
      push.count = s_valid_ff ? 2'(close_v) + 2'(tail_v) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         ts_ff   <= '0;
         wlen_ff <= '0;
      end else if (s_valid_ff) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         ts_ff   <= ts_in;
         wlen_ff <= wlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s_valid_ff) begin
         chars_ff <= chars_in;
      end
   end

   stk_span_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_span  (out_span),
      .level     (level)
   );

   assign rsp_tdata = {6'b0, out_span.span_class, out_span.span_end, out_span.span_start};
   assign rsp_tlast = out_span.last_span;

endmodule

`default_nettype wire

FILE: src/stk_checker.sv
// Port-level checks for the token highlighter and their binding to the top level.
`default_nettype none

module stk_checker
   import stk_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_tvalid,
   input wire logic        csr_tready,
   input wire logic [7:0]  csr_tdata
);

   logic [16:0] span_len;

   assign span_len = {1'b0, rsp_tdata[31:16]} - {1'b0, rsp_tdata[15:0]};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled span changed");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] >= rsp_tdata[15:0])
      else $error("span ends before it starts");

   a_keyword_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] == CLS_KEYWORD |-> span_len <= 17'(KW_CHARS))
      else $error("keyword span longer than any keyword");

   a_no_req_unused: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tlast) || !req_tvalid)
      else $error("accepted character with unknown end marker");

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_tvalid, csr_tready, csr_tdata};

endmodule

bind source_token_highlighter stk_checker u_checker (.*);

`default_nettype wire
